// ===== src/arpc_pkg.sv =====
// Package with the shared types, widths and codes of the ARP responder and cache.
`default_nettype none

package arpc_pkg;

	localparam int MAC_W     = 48;
	localparam int IP_W      = 32;
	localparam int ACT_W     = 2;
	localparam int OPC_W     = 16;
	localparam int SOPC_W    = 2;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 48;

	// Event actions
	localparam logic [ACT_W-1:0] ACT_RX     = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SEND   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

	// ARP operations seen on the wire
	localparam logic [OPC_W-1:0] OP_REQUEST = 16'h0001;
	localparam logic [OPC_W-1:0] OP_REPLY   = 16'h0002;

	// Operation of a transmitted packet
	localparam logic [SOPC_W-1:0] SEND_NONE    = 2'd0;
	localparam logic [SOPC_W-1:0] SEND_REQUEST = 2'd1;
	localparam logic [SOPC_W-1:0] SEND_REPLY   = 2'd2;

	// Result status
	localparam logic [STAT_W-1:0] STAT_HANDLED = 2'd0;
	localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_OP  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP  = 2'd1;

	localparam logic [IP_W-1:0]  LOCAL_IP_RESET  = 32'hC0A8_0509;
	localparam logic [MAC_W-1:0] LOCAL_MAC_RESET = '0;
	localparam logic [MAC_W-1:0] MAC_BROADCAST   = {MAC_W{1'b1}};

	typedef struct packed {
		logic [MAC_W-1:0] local_mac;
		logic [IP_W-1:0]  local_ip;
	} cfg_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [OPC_W-1:0] opcode;
		logic [MAC_W-1:0] sender_mac;
		logic [IP_W-1:0]  sender_ip;
		logic [IP_W-1:0]  target_ip;
	} evt_item_t;

	typedef struct packed {
		logic              send_valid;
		logic [SOPC_W-1:0] send_opcode;
		logic [MAC_W-1:0]  dest_mac;
		logic [MAC_W-1:0]  out_target_mac;
		logic [IP_W-1:0]   out_target_ip;
		logic              lookup_hit;
		logic [MAC_W-1:0]  lookup_mac;
		logic [STAT_W-1:0] status;
	} res_item_t;

	// One cache entry as held in the table memory
	typedef struct packed {
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} ctrl_state_t;

endpackage

`default_nettype wire

// ===== src/arpc_ifs.sv =====
// Handshake interfaces for the event, result and configuration channels.
`default_nettype none

interface arpc_evt_if;
	import arpc_pkg::*;
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [OPC_W-1:0] opcode;
	logic [MAC_W-1:0] sender_mac;
	logic [IP_W-1:0]  sender_ip;
	logic [IP_W-1:0]  target_ip;

	modport source (output valid, action, opcode, sender_mac, sender_ip, target_ip,
		input ready);
	modport sink (input valid, action, opcode, sender_mac, sender_ip, target_ip,
		output ready);
endinterface

interface arpc_res_if;
	import arpc_pkg::*;
	logic              valid;
	logic              ready;
	logic              send_valid;
	logic [SOPC_W-1:0] send_opcode;
	logic [MAC_W-1:0]  dest_mac;
	logic [MAC_W-1:0]  out_target_mac;
	logic [IP_W-1:0]   out_target_ip;
	logic              lookup_hit;
	logic [MAC_W-1:0]  lookup_mac;
	logic [STAT_W-1:0] status;

	modport source (output valid, send_valid, send_opcode, dest_mac, out_target_mac,
		out_target_ip, lookup_hit, lookup_mac, status, input ready);
	modport sink (input valid, send_valid, send_opcode, dest_mac, out_target_mac,
		out_target_ip, lookup_hit, lookup_mac, status, output ready);
endinterface

interface arpc_cfg_if;
	import arpc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/arp_responder_and_cache_top.sv =====
// Top level of the ARP responder with its IP-to-MAC cache.
//
// Channels: evt takes one ARP event word (received packet, send request or
// lookup), res returns exactly one result word per event, cfg writes the
// local MAC (index 0) and local IP (index 1); cfg is always ready.
// An event that needs no table access (request, send, unknown opcode) has
// its result registered at acceptance and then moved to the output register.
// A received reply or a lookup scans the cache one entry per cycle through
// the table memory's single read port, until a hit or past the last filled
// entry. One event at a time: evt.ready is high only while the sequencer is
// idle. The finished result sits in an output register; a stalled receiver
// holds it and the next event is accepted meanwhile, but its own result
// waits until the register is free.
// Reset: the cache is empty (fill count zero; memory contents are never
// read before written), local MAC is zero and local IP is 192.168.5.9.
// Configuration is to be written by the user only while no event is in
// flight; the block itself does not enforce it.
`default_nettype none

module arp_responder_and_cache_top #(
	parameter int TABLE_ENTRIES = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	arpc_evt_if.sink   evt,
	arpc_res_if.source res,
	arpc_cfg_if.sink   cfg
);

	import arpc_pkg::*;

	localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	cfg_t    cfg_q;
	logic    ram_wr_en;
	logic    ram_rd_en;
	logic [AW-1:0] ram_wr_addr;
	logic [AW-1:0] ram_rd_addr;
	entry_t  ram_wr_data;
	entry_t  ram_rd_data;

	assign cfg.ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_mac <= LOCAL_MAC_RESET;
			cfg_q.local_ip  <= LOCAL_IP_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_LOCAL_MAC: cfg_q.local_mac <= cfg.data[MAC_W-1:0];
				CFG_LOCAL_IP:  cfg_q.local_ip  <= cfg.data[IP_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	arpc_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.AW(AW),
		.CNT_W(CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt),
		.res        (res),
		.cfg_regs   (cfg_q),
		.ram_wr_en  (ram_wr_en),
		.ram_wr_addr(ram_wr_addr),
		.ram_wr_data(ram_wr_data),
		.ram_rd_en  (ram_rd_en),
		.ram_rd_addr(ram_rd_addr),
		.ram_rd_data(ram_rd_data)
	);

	arpc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES),
		.AW(AW)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

endmodule

`default_nettype wire

// ===== src/arpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/arpc_ctrl.sv =====
// Event sequencer: decodes words, scans the cache table, appends entries, builds results.
`default_nettype none

module arpc_ctrl #(
	parameter int TABLE_ENTRIES = 16,
	parameter int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	parameter int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	arpc_evt_if.sink                   evt,
	arpc_res_if.source                 res,
	input  wire arpc_pkg::cfg_t        cfg_regs,
	output logic                       ram_wr_en,
	output logic      [AW-1:0]         ram_wr_addr,
	output arpc_pkg::entry_t           ram_wr_data,
	output logic                       ram_rd_en,
	output logic      [AW-1:0]         ram_rd_addr,
	input  wire arpc_pkg::entry_t      ram_rd_data
);

	import arpc_pkg::*;

	ctrl_state_t state_q, state_d;
	evt_item_t   item_q;
	res_item_t   rslt_q;
	res_item_t   out_q;
	res_item_t   imm_rslt;
	res_item_t   scan_rslt;
	logic        out_valid_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic        pend_s1;

	logic        evt_ready;
	logic        scanning;
	logic        accept;
	logic        needs_scan;
	logic        is_lookup;
	logic [IP_W-1:0] key;
	logic        hit;
	logic        miss;
	logic        full;
	logic        out_free;
	logic        load_out;

	assign accept   = evt.valid && evt_ready;
	assign out_free = !out_valid_q || res.ready;
	assign is_lookup = (item_q.action == ACT_LOOKUP);
	assign key      = is_lookup ? item_q.target_ip : item_q.sender_ip;
	assign full     = (cnt_q == CNT_W'(TABLE_ENTRIES));
	assign hit      = scanning && pend_s1 && (ram_rd_data.ip == key);
	assign miss     = scanning && !pend_s1 && (scan_idx_q == cnt_q);
	assign needs_scan = ((evt.action == ACT_RX) && (evt.opcode == OP_REPLY))
		|| (evt.action == ACT_LOOKUP);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = needs_scan ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				if (hit || miss) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		evt_ready = 1'b0;
		scanning  = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: evt_ready = 1'b1;
			S_SCAN: scanning  = 1'b1;
			S_DONE: load_out  = out_free;
			default: begin
				evt_ready = 1'b0;
			end
		endcase
	end

	// Issue one table read per cycle while filled entries remain
	assign ram_rd_en   = scanning && (scan_idx_q != cnt_q);
	assign ram_rd_addr = scan_idx_q[AW-1:0];

	// Append a new pair at the fill point on a reply that missed, unless the table is full
	assign ram_wr_en        = miss && !is_lookup && !full;
	assign ram_wr_addr      = cnt_q[AW-1:0];
	assign ram_wr_data.ip   = item_q.sender_ip;
	assign ram_wr_data.mac  = item_q.sender_mac;

	// Result of events that need no table access
	always_comb begin
		imm_rslt = '0;
		case (evt.action)
			ACT_RX: begin
				if (evt.opcode == OP_REQUEST) begin
					if (evt.target_ip == cfg_regs.local_ip) begin
						imm_rslt.send_valid     = 1'b1;
						imm_rslt.send_opcode    = SEND_REPLY;
						imm_rslt.dest_mac       = evt.sender_mac;
						imm_rslt.out_target_mac = evt.sender_mac;
						imm_rslt.out_target_ip  = evt.sender_ip;
						imm_rslt.status         = STAT_HANDLED;
					end else begin
						imm_rslt.status = STAT_IGNORED;
					end
				end else if (evt.opcode != OP_REPLY) begin
					imm_rslt.status = STAT_BAD_OP;
				end
			end
			ACT_SEND: begin
				imm_rslt.send_valid    = 1'b1;
				imm_rslt.send_opcode   = SEND_REQUEST;
				imm_rslt.dest_mac      = MAC_BROADCAST;
				imm_rslt.out_target_ip = evt.target_ip;
				imm_rslt.status        = STAT_HANDLED;
			end
			ACT_LOOKUP: imm_rslt.status = STAT_HANDLED;
			default:    imm_rslt.status = STAT_IGNORED;
		endcase
	end

	// Result at the end of a table scan
	always_comb begin
		scan_rslt = '0;
		if (is_lookup) begin
			scan_rslt.status = STAT_HANDLED;
			if (hit) begin
				scan_rslt.lookup_hit = 1'b1;
				scan_rslt.lookup_mac = ram_rd_data.mac;
			end
		end else if (hit) begin
			scan_rslt.status = STAT_IGNORED;
		end else begin
			scan_rslt.status = full ? STAT_FULL : STAT_HANDLED;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			scan_idx_q  <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				scan_idx_q <= '0;
				pend_s1    <= 1'b0;
			end else if (scanning) begin
				pend_s1 <= ram_rd_en;
				if (ram_rd_en) begin
					scan_idx_q <= scan_idx_q + CNT_W'(1);
				end
			end
			if (ram_wr_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.action     <= evt.action;
			item_q.opcode     <= evt.opcode;
			item_q.sender_mac <= evt.sender_mac;
			item_q.sender_ip  <= evt.sender_ip;
			item_q.target_ip  <= evt.target_ip;
			rslt_q            <= imm_rslt;
		end else if (hit || miss) begin
			rslt_q <= scan_rslt;
		end
		if (load_out) begin
			out_q <= rslt_q;
		end
	end

	assign evt.ready          = evt_ready;
	assign res.valid          = out_valid_q;
	assign res.send_valid     = out_q.send_valid;
	assign res.send_opcode    = out_q.send_opcode;
	assign res.dest_mac       = out_q.dest_mac;
	assign res.out_target_mac = out_q.out_target_mac;
	assign res.out_target_ip  = out_q.out_target_ip;
	assign res.lookup_hit     = out_q.lookup_hit;
	assign res.lookup_mac     = out_q.lookup_mac;
	assign res.status         = out_q.status;

endmodule

`default_nettype wire

// ===== src/arpc_checker.sv =====
// Port checker for the ARP responder top level and its bind statement.
`default_nettype none

module arpc_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        evt_valid,
	input wire logic                        evt_ready,
	input wire logic                        res_valid,
	input wire logic                        res_ready,
	input wire logic                        send_valid,
	input wire logic [arpc_pkg::SOPC_W-1:0] send_opcode,
	input wire logic [arpc_pkg::MAC_W-1:0]  dest_mac,
	input wire logic [arpc_pkg::MAC_W-1:0]  out_target_mac,
	input wire logic                        lookup_hit,
	input wire logic [arpc_pkg::STAT_W-1:0] status
);

	import arpc_pkg::*;

	// One event in flight: no event is taken right after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready |=> !evt_ready)
		else $error("event accepted while previous one in flight");

	// A transmitted packet carries a request or reply operation
	a_send_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && send_valid |-> (send_opcode == SEND_REQUEST) ||
			(send_opcode == SEND_REPLY))
		else $error("sent packet without valid operation");

	// A reply goes back to the requester and counts as handled
	a_reply_dest: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && send_opcode == SEND_REPLY |->
			dest_mac == out_target_mac && status == STAT_HANDLED)
		else $error("reply destination or status mismatch");

	// A lookup hit sends nothing and counts as handled
	a_hit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && lookup_hit |-> !send_valid && status == STAT_HANDLED)
		else $error("lookup hit with packet or bad status");

	// A stalled result word stays valid with its status and destination held
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) &&
			$stable(dest_mac))
		else $error("stalled result changed");

endmodule

bind arp_responder_and_cache_top arpc_checker u_arpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.evt_valid     (evt.valid),
	.evt_ready     (evt.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.send_valid    (res.send_valid),
	.send_opcode   (res.send_opcode),
	.dest_mac      (res.dest_mac),
	.out_target_mac(res.out_target_mac),
	.lookup_hit    (res.lookup_hit),
	.status        (res.status)
);

`default_nettype wire
